@@ rtl/bpa_pkg.sv @@
// Shared types, constants and helper functions for the bitmap page allocator.
// Depends on nothing; bitmap_page_allocator and the testbench import it.
`default_nettype none

package bpa_pkg;

  localparam int PAGE_CAPACITY = 4096;
  localparam int PAGE_SHIFT    = 12;
  localparam int ADDR_W        = 32;
  localparam int CNT_W         = $clog2(PAGE_CAPACITY) + 1;
  localparam int PAGE_IDX_W    = $clog2(PAGE_CAPACITY);
  localparam int ROW_W         = 256;
  localparam int BIT_IDX_W     = $clog2(ROW_W);
  localparam int ROWS          = PAGE_CAPACITY / ROW_W;
  localparam int ROW_ADDR_W    = $clog2(ROWS);

  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [ROW_ADDR_W-1:0] row_addr_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NOFREE = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_RSVD   = 2'd3
  } status_t;

  typedef enum logic {
    CFG_USABLE   = 1'b0,
    CFG_RESERVED = 1'b1
  } cfg_reg_t;

  // Bits of row w whose page index lies below x.
  function automatic row_t row_below(input cnt_t x, input row_addr_t w);
    row_t                           m;
    logic [CNT_W-BIT_IDX_W-1:0]     hi;
    hi = x[CNT_W-1:BIT_IDX_W];
    m  = '0;
    if (hi > {1'b0, w}) begin
      m = '1;
    end else if (hi == {1'b0, w}) begin
      for (int j = 0; j < ROW_W; j++) begin
        m[j] = (BIT_IDX_W'(j) < x[BIT_IDX_W-1:0]);
      end
    end
    return m;
  endfunction

  // Index of the lowest set bit; only meaningful when some bit is set.
  function automatic bit_idx_t first_set(input row_t v);
    bit_idx_t idx;
    idx = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        idx = BIT_IDX_W'(j);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bpa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_page_allocator.sv @@
// Top level of the first-fit bitmap page allocator.
// Depends on bpa_pkg and bpa_ram.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one transaction: in_mode selects
//   allocate, free or initialize, in_page_address names the page to free.
//   Each input transaction yields exactly one output transaction carrying the
//   allocated address, a status code and the free page count after the item.
//   The configuration channel writes usable_pages (index 0) and reserved_pages
//   (index 1); it is always ready and is meant to be used while the block idles.
//   The used/free map lives in a 16 x 256-bit RAM, one row read per cycle.
//   Steps from input acceptance until the result goes to the output register:
//     allocate:    scan rows in order (1 to 16 rows), or none when no page
//                  is usable
//     free:        update the addressed row; out-of-range address or unused mode go straight to the response
//     initialize:  write all 16 RAM rows in order, one row per cycle
//   One item is in flight at a time; the next is taken once the result has
//   moved to the output register, so a stalled receiver holds one result while
//   the block works on the next one.
//   Reset marks every page used via per-row valid flags (no clearing pass),
//   clears the free count, and sets usable_pages to 0, reserved_pages to 256.
`default_nettype none

module bitmap_page_allocator (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_mode,
  input  wire bpa_pkg::addr_t        in_page_address,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bpa_pkg::addr_t             out_alloc_address,
  output logic [1:0]                 out_status,
  output bpa_pkg::cnt_t              out_free_count,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire bpa_pkg::cnt_t         cfg_data
);

  import bpa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ALLOC,
    ST_FREE,
    ST_RESP
  } state_t;

  state_t      state_r, state_nxt;
  row_addr_t   row_r, row_nxt;
  bit_idx_t    bit_r, bit_nxt;
  cnt_t        count_r, count_nxt;
  logic [ROWS-1:0] valid_r, valid_nxt;
  cnt_t        usable_r, reserved_r;
  addr_t       res_addr_r, res_addr_nxt;
  status_t     res_status_r, res_status_nxt;
  logic        out_valid_r, out_valid_nxt;
  addr_t       out_addr_r, out_addr_nxt;
  status_t     out_status_r, out_status_nxt;
  cnt_t        out_count_r, out_count_nxt;

  logic        wr_en;
  row_addr_t   wr_addr;
  row_t        wr_data;
  row_addr_t   rd_addr;
  row_t        rd_data;

  cnt_t        lim;
  cnt_t        res;
  row_t        eff_row;
  row_t        avail;
  bit_idx_t    hit_idx;
  logic [ROW_ADDR_W:0] next_row;

  bpa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign lim = (usable_r > cnt_t'(PAGE_CAPACITY)) ? cnt_t'(PAGE_CAPACITY) : usable_r;
  assign res = (reserved_r > cnt_t'(PAGE_CAPACITY)) ? cnt_t'(PAGE_CAPACITY) : reserved_r;

  // A row never written since reset reads as all pages used.
  assign eff_row  = valid_r[row_r] ? rd_data : '1;
  assign avail    = ~eff_row & row_below(lim, row_r);
  assign hit_idx  = first_set(avail);
  assign next_row = {1'b0, row_r} + (ROW_ADDR_W+1)'(1);

  assign in_ready          = (state_r == ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_alloc_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_count    = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    bit_nxt        = bit_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = row_r;
    wr_data        = eff_row;
    rd_addr        = next_row[ROW_ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_addr_nxt   = '0;
          res_status_nxt = STATUS_OK;
          unique case (mode_t'(in_mode))
            MODE_ALLOC: begin
              rd_addr = '0;
              row_nxt = '0;
              if (lim == '0) begin
                res_status_nxt = STATUS_NOFREE;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_ALLOC;
              end
            end
            MODE_FREE: begin
              rd_addr = in_page_address[PAGE_SHIFT+PAGE_IDX_W-1:PAGE_SHIFT+BIT_IDX_W];
              row_nxt = in_page_address[PAGE_SHIFT+PAGE_IDX_W-1:PAGE_SHIFT+BIT_IDX_W];
              bit_nxt = in_page_address[PAGE_SHIFT+BIT_IDX_W-1:PAGE_SHIFT];
              if (in_page_address[ADDR_W-1:PAGE_SHIFT+PAGE_IDX_W] != '0) begin
                res_status_nxt = STATUS_RANGE;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_FREE;
              end
            end
            MODE_INIT: begin
              count_nxt = (lim > res) ? cnt_t'(lim - res) : '0;
              row_nxt   = '0;
              state_nxt = ST_INIT;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_INIT: begin
        wr_en            = 1'b1;
        wr_data          = ~(row_below(lim, row_r) & ~row_below(res, row_r));
        valid_nxt[row_r] = 1'b1;
        if (row_r == row_addr_t'(ROWS - 1)) begin
          state_nxt = ST_RESP;
        end else begin
          row_nxt = next_row[ROW_ADDR_W-1:0];
        end
      end

      ST_ALLOC: begin
        // The read of the following row is already issued this cycle.
        if (avail != '0) begin
          wr_en            = 1'b1;
          wr_data          = eff_row | (row_t'(1) << hit_idx);
          valid_nxt[row_r] = 1'b1;
          count_nxt        = count_r - cnt_t'(1);
          res_addr_nxt     = addr_t'({row_r, hit_idx}) << PAGE_SHIFT;
          state_nxt        = ST_RESP;
        end else if ({next_row, BIT_IDX_W'(0)} < lim) begin
          row_nxt = next_row[ROW_ADDR_W-1:0];
        end else begin
          res_status_nxt = STATUS_NOFREE;
          state_nxt      = ST_RESP;
        end
      end

      ST_FREE: begin
        if (eff_row[bit_r]) begin
          wr_en            = 1'b1;
          wr_data          = eff_row & ~(row_t'(1) << bit_r);
          valid_nxt[row_r] = 1'b1;
          count_nxt        = count_r + cnt_t'(1);
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      usable_r    <= '0;
      reserved_r  <= cnt_t'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index[1] == 1'b0) begin
        if (cfg_reg_t'(cfg_index[0]) == CFG_USABLE) begin
          usable_r <= cfg_data;
        end else begin
          reserved_r <= cfg_data;
        end
      end
    end
    row_r        <= row_nxt;
    bit_r        <= bit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire

@@ sim/tb_bitmap_page_allocator.sv @@
// Self-checking testbench for the first-fit bitmap page allocator.
// Depends on bpa_pkg and the bitmap_page_allocator RTL; it predicts every result in place.
// Directed corner cases first, then randomized phases across several register settings.

module tb_bitmap_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int          NUM_PHASES      = 10;
  localparam int          ITEMS_PER_PHASE = 88;
  localparam int          SETTLE_CYCLES   = 24;
  localparam int          IDLE_LIMIT      = 2000;
  localparam int          PRINT_LIMIT     = 40;
  localparam logic [1:0]  CFG_NO_REG      = 2'd3;

  typedef struct {
    mode_t mode;
    addr_t address;
  } page_req_t;

  typedef struct {
    addr_t   address;
    status_t status;
    cnt_t    free_count;
  } page_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = '0;
  addr_t      in_page_address = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  addr_t      out_alloc_address;
  logic [1:0] out_status;
  cnt_t       out_free_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  cnt_t       cfg_data = '0;

  // Shadow copy of the allocator state and its registers.
  bit          page_used [PAGE_CAPACITY];
  int unsigned shadow_free_count;
  int unsigned usable_reg;
  int unsigned reserved_reg;

  page_req_t   queued_reqs[$];
  page_reply_t awaited_replies[$];
  page_req_t   driven_req;
  page_reply_t got_reply;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;
  bit          in_gaps_on = 1'b0;
  bit          out_stalls_on = 1'b0;
  int unsigned allocs_since_init = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  int unsigned phase_usable [NUM_PHASES];
  int unsigned phase_reserved [NUM_PHASES];
  bit          phase_init [NUM_PHASES];

  bitmap_page_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_page_address   (in_page_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_alloc_address (out_alloc_address),
    .out_status        (out_status),
    .out_free_count    (out_free_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp_pages(input int unsigned n);
    return (n > PAGE_CAPACITY) ? PAGE_CAPACITY : n;
  endfunction

  function automatic void rebuild_map();
    int unsigned lim;
    int unsigned rsv;
    lim = clamp_pages(usable_reg);
    rsv = clamp_pages(reserved_reg);
    shadow_free_count = 0;
    for (int p = 0; p < PAGE_CAPACITY; p++) begin
      page_used[p] = (p >= lim) || (p < rsv);
      if (!page_used[p]) begin
        shadow_free_count++;
      end
    end
  endfunction

  function automatic page_reply_t apply_page_op(input page_req_t req);
    page_reply_t r;
    int unsigned lim;
    logic [31:0] page;
    bit          found;
    r.address = '0;
    r.status  = STATUS_OK;
    found     = 1'b0;
    case (req.mode)
      MODE_ALLOC: begin
        lim = clamp_pages(usable_reg);
        for (int unsigned p = 0; p < lim && !found; p++) begin
          if (!page_used[p]) begin
            page_used[p] = 1'b1;
            shadow_free_count--;
            r.address = addr_t'(p << PAGE_SHIFT);
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = STATUS_NOFREE;
        end
      end
      MODE_FREE: begin
        page = req.address >> PAGE_SHIFT;
        if (page >= PAGE_CAPACITY) begin
          r.status = STATUS_RANGE;
        end else if (page_used[page]) begin
          page_used[page] = 1'b0;
          shadow_free_count++;
        end
      end
      MODE_INIT: begin
        rebuild_map();
      end
      default: begin
      end
    endcase
    r.free_count = cnt_t'(shadow_free_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 48);
  endfunction

  // Frees mostly target the low window where recent allocations landed, so they
  // hit used pages; the rest spread over the whole map or the full address space.
  function automatic page_req_t random_req();
    page_req_t   r;
    int unsigned roll;
    int unsigned window;
    int unsigned page;
    roll      = $urandom_range(0, 99);
    r.address = $urandom();
    if (roll < 50) begin
      r.mode = MODE_ALLOC;
      allocs_since_init++;
    end else if (roll < 92) begin
      r.mode = MODE_FREE;
      roll = $urandom_range(0, 9);
      if (roll < 9) begin
        window = clamp_pages(reserved_reg) + allocs_since_init + 4;
        if (roll < 7 && window < PAGE_CAPACITY) begin
          page = $urandom_range(0, window);
        end else begin
          page = $urandom_range(0, PAGE_CAPACITY - 1);
        end
        r.address = (addr_t'(page) << PAGE_SHIFT) |
                    (r.address & addr_t'((1 << PAGE_SHIFT) - 1));
      end
    end else if (roll < 96) begin
      r.mode = MODE_INIT;
      allocs_since_init = 0;
    end else begin
      r.mode = MODE_NONE;
    end
    return r;
  endfunction

  function automatic void push_req(input mode_t mode, input addr_t address);
    page_req_t r;
    r.mode    = mode;
    r.address = address;
    queued_reqs.push_back(r);
  endfunction

  task automatic note_mismatch(input string what);
    if (errors < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    errors++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cnt_t'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_USABLE) begin
      usable_reg = int'(cnt_t'(value));
    end else if (idx == CFG_RESERVED) begin
      reserved_reg = int'(cnt_t'(value));
    end
  endtask

  // Returns once every queued request went in and every result came back.
  task automatic drain();
    do @(negedge clk);
    while (queued_reqs.size() != 0 || in_valid || awaited_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: the prediction is made at the edge that accepts the transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_replies.push_back(apply_page_op(driven_req));
      end
      if (!in_valid || in_ready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (queued_reqs.size() > 0) begin
          driven_req = queued_reqs.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= driven_req.mode;
          in_page_address <= driven_req.address;
          in_gap_left = in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: addr=%h status=%0d count=%0d",
                                  out_alloc_address, out_status, out_free_count));
        end else begin
          got_reply = awaited_replies.pop_front();
          if (out_alloc_address !== got_reply.address) begin
            note_mismatch($sformatf("alloc_address %h, expected %h",
                                    out_alloc_address, got_reply.address));
          end
          if (out_status !== got_reply.status) begin
            note_mismatch($sformatf("status %0d, expected %s",
                                    out_status, got_reply.status.name()));
          end
          if (out_free_count !== got_reply.free_count) begin
            note_mismatch($sformatf("free_count %0d, expected %0d",
                                    out_free_count, got_reply.free_count));
          end
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 3) == 0) begin
          out_stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int p = 0; p < PAGE_CAPACITY; p++) begin
      page_used[p] = 1'b1;
    end
    shadow_free_count = 0;
    usable_reg        = 0;
    reserved_reg      = 256;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: every page used, nothing usable.
    push_req(MODE_ALLOC, '0);
    push_req(MODE_FREE,  32'h0000_0ABC);
    push_req(MODE_FREE,  32'h0000_0000);
    push_req(MODE_ALLOC, '0);
    push_req(MODE_FREE,  32'h00FF_FFFF);
    push_req(MODE_FREE,  32'h0100_0000);
    push_req(MODE_FREE,  32'hFFFF_FFFF);
    push_req(MODE_NONE,  32'hFFFF_FFFF);
    push_req(MODE_INIT,  '0);
    drain();

    // Oversized registers clamp to capacity; a write to an unmapped index is dropped.
    write_reg(CFG_NO_REG, 8191);
    write_reg(CFG_USABLE, 8191);
    write_reg(CFG_RESERVED, 0);
    push_req(MODE_INIT,  '0);
    push_req(MODE_ALLOC, '0);
    push_req(MODE_ALLOC, '0);
    push_req(MODE_FREE,  32'h0000_1FFF);
    push_req(MODE_ALLOC, '0);
    push_req(MODE_ALLOC, 32'hFFFF_FFFF);
    push_req(MODE_NONE,  '0);
    drain();

    // Shrink the usable range without init, then reserve more than is usable.
    write_reg(CFG_USABLE, 10);
    write_reg(CFG_RESERVED, 20);
    push_req(MODE_ALLOC, '0);
    push_req(MODE_INIT,  '0);
    push_req(MODE_ALLOC, '0);
    drain();

    phase_usable   = '{4096, 40, 300, 4096, 8191, 200, 0, 0, 0, 0};
    phase_reserved = '{0, 8, 256, 4096, 100, 8191, 0, 0, 0, 0};
    phase_init     = '{1, 1, 0, 1, 1, 1, 1, 1, 0, 1};
    for (int ph = 6; ph < NUM_PHASES; ph++) begin
      phase_usable[ph]   = (ph < 8) ? $urandom_range(0, 64) : $urandom_range(0, 600);
      phase_reserved[ph] = $urandom_range(0, 400);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      write_reg(CFG_USABLE, phase_usable[ph]);
      write_reg(CFG_RESERVED, phase_reserved[ph]);
      allocs_since_init = 0;
      if (phase_init[ph]) begin
        push_req(MODE_INIT, $urandom());
      end
      repeat (ITEMS_PER_PHASE) queued_reqs.push_back(random_req());
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ bitmap_page_allocator.f @@
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bitmap_page_allocator.sv
sim/tb_bitmap_page_allocator.sv
